// ===== hdl/cqe_pkg.sv =====
// ----------------------------------------------------------------------------
// cqe_pkg
// Shared types, constants and helpers of the circular queue engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cqe_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int MIN_SLOTS = 2;
  localparam int PTR_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int VALUE_W   = 31;
  localparam int OPCODE_W  = 2;
  localparam int STATUS_W  = 3;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_DUMP    = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED     = 3'd0,
    ST_OVERFLOW   = 3'd1,
    ST_DEQUEUED   = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_DUMP_ELEM  = 3'd4,
    ST_DUMP_EMPTY = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    in_ready;
    logic    out_valid;
    logic    ram_we;
    logic    wp_adv;
    logic    rd_en;
    logic    rd_from_scan;
    logic    scan_adv;
    logic    rp_adv;
    logic    res_load;
    logic    res_from_ram;
    logic    res_last_from_scan;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic out_last;
  } stat_t;

  function automatic ptr_t advance(input ptr_t p, input cnt_t slots);
    cnt_t nxt;
    nxt = cnt_t'(p) + cnt_t'(1);
    return (nxt >= slots) ? ptr_t'(0) : nxt[PTR_W-1:0];
  endfunction

  function automatic cnt_t clamp_slots(input cnt_t v);
    if (v < cnt_t'(MIN_SLOTS)) begin
      return cnt_t'(MIN_SLOTS);
    end else if (v > cnt_t'(MAX_SLOTS)) begin
      return cnt_t'(MAX_SLOTS);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cqe_if.sv =====
// ----------------------------------------------------------------------------
// cqe_if
// Request and response channels of the circular queue engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface cqe_req_if;
  logic                         valid;
  logic                         ready;
  logic [cqe_pkg::OPCODE_W-1:0] opcode;
  logic [cqe_pkg::VALUE_W-1:0]  push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface cqe_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cqe_pkg::STATUS_W-1:0] status;
  logic [cqe_pkg::VALUE_W-1:0]  out_value;
  logic                         last;

  modport source (output valid, output status, output out_value, output last, input ready);
  modport sink   (input valid, input status, input out_value, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/cqe_ram.sv =====
// ----------------------------------------------------------------------------
// cqe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cqe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cqe_ctrl.sv =====
// ----------------------------------------------------------------------------
// cqe_ctrl
// Controller: sequences enqueue, dequeue and dump items over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module cqe_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [cqe_pkg::OPCODE_W-1:0] opcode,
  input  wire logic                         out_ready,
  input  wire cqe_pkg::stat_t               stat,
  output cqe_pkg::cmd_t                     cmd
);

  cqe_pkg::state_t state, state_next;
  logic            dumping, dumping_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cqe_pkg::S_IDLE;
      dumping <= 1'b0;
    end else begin
      state   <= state_next;
      dumping <= dumping_next;
    end
  end

  always_comb begin
    state_next   = state;
    dumping_next = dumping;
    cmd          = '0;
    cmd.res_status = cqe_pkg::ST_STORED;
    case (state)
      cqe_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          dumping_next = 1'b0;
          case (cqe_pkg::opcode_t'(opcode))
            cqe_pkg::OP_ENQUEUE: begin
              cmd.res_load = 1'b1;
              if (stat.full) begin
                cmd.res_status = cqe_pkg::ST_OVERFLOW;
              end else begin
                cmd.res_status = cqe_pkg::ST_STORED;
                cmd.ram_we     = 1'b1;
                cmd.wp_adv     = 1'b1;
              end
              state_next = cqe_pkg::S_OUT;
            end
            cqe_pkg::OP_DEQUEUE: begin
              if (stat.empty) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = cqe_pkg::ST_EMPTY;
                state_next     = cqe_pkg::S_OUT;
              end else begin
                cmd.rd_en  = 1'b1;
                state_next = cqe_pkg::S_READ;
              end
            end
            cqe_pkg::OP_DUMP: begin
              if (stat.empty) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = cqe_pkg::ST_DUMP_EMPTY;
                state_next     = cqe_pkg::S_OUT;
              end else begin
                cmd.rd_en    = 1'b1;
                dumping_next = 1'b1;
                state_next   = cqe_pkg::S_READ;
              end
            end
            default: begin
              state_next = cqe_pkg::S_IDLE;
            end
          endcase
        end
      end
      cqe_pkg::S_READ: begin
        cmd.res_load     = 1'b1;
        cmd.res_from_ram = 1'b1;
        if (dumping) begin
          cmd.res_status         = cqe_pkg::ST_DUMP_ELEM;
          cmd.res_last_from_scan = 1'b1;
          cmd.scan_adv           = 1'b1;
        end else begin
          cmd.res_status = cqe_pkg::ST_DEQUEUED;
          cmd.rp_adv     = 1'b1;
        end
        state_next = cqe_pkg::S_OUT;
      end
      cqe_pkg::S_OUT: begin
        cmd.out_valid = 1'b1;
        if (out_ready) begin
          if (dumping && !stat.out_last) begin
            cmd.rd_en        = 1'b1;
            cmd.rd_from_scan = 1'b1;
            state_next       = cqe_pkg::S_READ;
          end else begin
            state_next = cqe_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = cqe_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/cqe_dp.sv =====
// ----------------------------------------------------------------------------
// cqe_dp
// Datapath: ring storage, read/write/scan pointers, slot count and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module cqe_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cqe_pkg::cmd_t                cmd,
  input  wire logic [cqe_pkg::VALUE_W-1:0]  push_value,
  input  wire logic                         cfg_we,
  input  wire logic [cqe_pkg::CNT_W-1:0]    cfg_wdata,
  output cqe_pkg::stat_t                    stat,
  output logic      [cqe_pkg::STATUS_W-1:0] res_status,
  output logic      [cqe_pkg::VALUE_W-1:0]  res_value,
  output logic                              res_last
);

  cqe_pkg::cnt_t   slot_count;
  cqe_pkg::ptr_t   rp;
  cqe_pkg::ptr_t   wp;
  cqe_pkg::ptr_t   scan;
  cqe_pkg::ptr_t   rd_addr;
  cqe_pkg::ptr_t   wp_adv_val;
  cqe_pkg::ptr_t   scan_adv_val;
  cqe_pkg::value_t rd_data;

  assign wp_adv_val   = cqe_pkg::advance(wp, slot_count);
  assign scan_adv_val = cqe_pkg::advance(scan, slot_count);
  assign rd_addr      = cmd.rd_from_scan ? scan : rp;

  assign stat.full     = (wp_adv_val == rp);
  assign stat.empty    = (rp == wp);
  assign stat.out_last = res_last;

  cqe_ram #(
    .WIDTH (cqe_pkg::VALUE_W),
    .DEPTH (cqe_pkg::MAX_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (wp),
    .wdata (push_value),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= cqe_pkg::cnt_t'(cqe_pkg::MAX_SLOTS);
      rp         <= '0;
      wp         <= '0;
    end else if (cfg_we) begin
      slot_count <= cqe_pkg::clamp_slots(cfg_wdata);
      rp         <= '0;
      wp         <= '0;
    end else begin
      if (cmd.wp_adv) begin
        wp <= wp_adv_val;
      end
      if (cmd.rp_adv) begin
        rp <= cqe_pkg::advance(rp, slot_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en && !cmd.rd_from_scan) begin
      scan <= rp;
    end else if (cmd.scan_adv) begin
      scan <= scan_adv_val;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_value  <= cmd.res_from_ram ? rd_data : '0;
      res_last   <= cmd.res_last_from_scan ? (scan_adv_val == wp) : 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/circular_queue_engine_top.sv =====
// ----------------------------------------------------------------------------
// circular_queue_engine_top
// Ring-buffer queue of 31-bit values with enqueue, dequeue and dump.
// ----------------------------------------------------------------------------
// The queue uses slot_count ring slots (2..64, reset 64) and holds at most one
// fewer values; writing cfg_wdata clamps it to that range and empties the
// queue. Each request item gives one response item, except a dump, which
// gives one item per stored value, oldest first, with last set on the final
// one (or a single dump-empty item), and opcode 3, which gives none. One item
// is in work at a time: an enqueue or any empty/overflow answer goes straight
// to the one response register, while a dequeue and each dumped value first
// pass through the registered read of the ring RAM; the next request is taken
// only after the response is taken. No clearing pass follows reset.
`default_nettype none

module circular_queue_engine_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  cqe_req_if.sink                        req,
  cqe_rsp_if.source                      rsp,
  input  wire logic                      cfg_we,
  input  wire logic [cqe_pkg::CNT_W-1:0] cfg_wdata
);

  cqe_pkg::cmd_t  cmd;
  cqe_pkg::stat_t stat;

  cqe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .opcode    (req.opcode),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cqe_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_value (req.push_value),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .stat       (stat),
    .res_status (rsp.status),
    .res_value  (rsp.out_value),
    .res_last   (rsp.last)
  );

  assign req.ready = cmd.in_ready;
  assign rsp.valid = cmd.out_valid;

endmodule

`default_nettype wire
